/* design/bos_pkg.sv */
package bos_pkg;

    // Set size and key width
    localparam int CAPACITY = 16;
    localparam int KEY_BITS = 32;

    // Slot address and count widths
    localparam int ADDR_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W  = $clog2(CAPACITY + 1);

    // Command codes on the input tuser
    localparam logic [1:0] CMD_INSERT = 2'd0;
    localparam logic [1:0] CMD_REMOVE = 2'd1;
    localparam logic [1:0] CMD_QUERY  = 2'd2;

    // Result status codes on the output tuser
    localparam logic [2:0] ST_INSERTED  = 3'd0;
    localparam logic [2:0] ST_FULL      = 3'd1;
    localparam logic [2:0] ST_DUPLICATE = 3'd2;
    localparam logic [2:0] ST_REMOVED   = 3'd3;
    localparam logic [2:0] ST_NOTFOUND  = 3'd4;
    localparam logic [2:0] ST_PRESENT   = 3'd5;

    // Controller states
    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_SHIFT,
        S_FINISH
    } ctrl_state_t;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic load;
        logic scan;
        logic shift;
        logic finish;
    } dp_cmd_t;

    // Status from the datapath to the controller
    typedef struct packed {
        logic scan_done;
        logic hit;
        logic is_remove;
        logic shift_done;
        logic out_free;
    } dp_stat_t;

endpackage

/* design/bos_ram.sv */
module bos_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

/* design/bos_ctrl.sv */
module bos_ctrl
    import bos_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    output logic     in_ready,
    input  dp_stat_t stat,
    output dp_cmd_t  cmd
);

    ctrl_state_t state_reg;
    ctrl_state_t state_next;

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = S_SCAN;
                end
            end
            S_SCAN:
            begin
                if (stat.scan_done)
                begin
                    state_next = (stat.hit && stat.is_remove) ? S_SHIFT : S_FINISH;
                end
            end
            S_SHIFT:
            begin
                if (stat.shift_done)
                begin
                    state_next = S_FINISH;
                end
            end
            S_FINISH:
            begin
                if (stat.out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Outputs
    always_comb
    begin
        in_ready   = 1'b0;
        cmd        = '0;
        case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                cmd.load = in_valid;
            end
            S_SCAN:
            begin
                cmd.scan = 1'b1;
            end
            S_SHIFT:
            begin
                cmd.shift = 1'b1;
            end
            S_FINISH:
            begin
                cmd.finish = stat.out_free;
            end
            default:
            begin
                in_ready = 1'b0;
            end
        endcase
    end

endmodule

/* design/bos_dp.sv */
module bos_dp
    import bos_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  dp_cmd_t     cmd,
    output dp_stat_t    stat,
    input  logic [1:0]  in_cmd,
    input  logic [31:0] in_key,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [2:0]  out_status,
    output logic [4:0]  out_count
);

    // Control registers
    logic [CNT_W-1:0]    cnt_reg, cnt_next;
    logic [CNT_W-1:0]    idx_reg, idx_next;
    logic                pend_reg, pend_next;
    logic                found_reg, found_next;
    logic                out_valid_reg, out_valid_next;

    // Payload registers
    logic [1:0]          cmd_reg, cmd_next;
    logic [KEY_BITS-1:0] key_reg, key_next;
    logic [ADDR_W-1:0]   rd_idx_reg, rd_idx_next;
    logic [2:0]          status_reg, status_next;
    logic [CNT_W-1:0]    res_cnt_reg, res_cnt_next;

    // Key RAM ports
    logic                ram_we;
    logic [ADDR_W-1:0]   ram_waddr;
    logic [KEY_BITS-1:0] ram_wdata;
    logic [KEY_BITS-1:0] ram_rdata;

    logic [63:0]         key_ext;
    logic                hit;
    logic                issue;
    logic [CNT_W+4:0]    cnt_ext;

    bos_ram #(
        .WIDTH (KEY_BITS),
        .DEPTH (CAPACITY),
        .AW    (ADDR_W)
    ) u_key_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (idx_reg[ADDR_W-1:0]),
        .rdata (ram_rdata)
    );

    assign key_ext = {32'b0, in_key};
    assign hit     = pend_reg && (ram_rdata == key_reg);
    assign issue   = (idx_reg < cnt_reg);

    // Status toward the controller
    always_comb
    begin
        stat.scan_done  = hit || (idx_reg == cnt_reg);
        stat.hit        = hit;
        stat.is_remove  = (cmd_reg == CMD_REMOVE);
        stat.shift_done = (idx_reg == cnt_reg);
        stat.out_free   = !out_valid_reg || out_ready;
    end

    // Scan, shift and commit
    always_comb
    begin
        cnt_next       = cnt_reg;
        idx_next       = idx_reg;
        pend_next      = pend_reg;
        found_next     = found_reg;
        cmd_next       = cmd_reg;
        key_next       = key_reg;
        rd_idx_next    = rd_idx_reg;
        status_next    = status_reg;
        res_cnt_next   = res_cnt_reg;
        ram_we         = 1'b0;
        ram_waddr      = rd_idx_reg - 1'b1;
        ram_wdata      = ram_rdata;
        out_valid_next = out_valid_reg && !out_ready;

        if (cmd.load)
        begin
            // Latch the command and restart the slot stream
            cmd_next   = in_cmd;
            key_next   = key_ext[KEY_BITS-1:0];
            idx_next   = '0;
            pend_next  = 1'b0;
            found_next = 1'b0;
        end
        else if (cmd.scan)
        begin
            if (hit)
            begin
                // Stop on the match and aim the shift at the slot after it
                found_next = 1'b1;
                idx_next   = CNT_W'(rd_idx_reg) + 1'b1;
                pend_next  = 1'b0;
            end
            else
            begin
                pend_next = issue;
                if (issue)
                begin
                    rd_idx_next = idx_reg[ADDR_W-1:0];
                    idx_next    = idx_reg + 1'b1;
                end
            end
        end
        else if (cmd.shift)
        begin
            // Move each later key down one slot
            ram_we    = pend_reg;
            pend_next = issue;
            if (issue)
            begin
                rd_idx_next = idx_reg[ADDR_W-1:0];
                idx_next    = idx_reg + 1'b1;
            end
        end
        else if (cmd.finish)
        begin
            case (cmd_reg)
                CMD_INSERT:
                begin
                    if (cnt_reg == CNT_W'(CAPACITY))
                    begin
                        status_next = ST_FULL;
                    end
                    else if (found_reg)
                    begin
                        status_next = ST_DUPLICATE;
                    end
                    else
                    begin
                        // Append at the tail
                        ram_we      = 1'b1;
                        ram_waddr   = cnt_reg[ADDR_W-1:0];
                        ram_wdata   = key_reg;
                        cnt_next    = cnt_reg + 1'b1;
                        status_next = ST_INSERTED;
                    end
                end
                CMD_REMOVE:
                begin
                    if (found_reg)
                    begin
                        cnt_next    = cnt_reg - 1'b1;
                        status_next = ST_REMOVED;
                    end
                    else
                    begin
                        status_next = ST_NOTFOUND;
                    end
                end
                default:
                begin
                    status_next = found_reg ? ST_PRESENT : ST_NOTFOUND;
                end
            endcase
            res_cnt_next   = cnt_next;
            out_valid_next = 1'b1;
        end
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg       <= '0;
            idx_reg       <= '0;
            pend_reg      <= 1'b0;
            found_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            cnt_reg       <= cnt_next;
            idx_reg       <= idx_next;
            pend_reg      <= pend_next;
            found_reg     <= found_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload
    always_ff @(posedge clk)
    begin
        cmd_reg     <= cmd_next;
        key_reg     <= key_next;
        rd_idx_reg  <= rd_idx_next;
        status_reg  <= status_next;
        res_cnt_reg <= res_cnt_next;
    end

    assign cnt_ext    = {5'b0, res_cnt_reg};
    assign out_valid  = out_valid_reg;
    assign out_status = status_reg;
    assign out_count  = cnt_ext[4:0];

endmodule

/* design/bounded_ordered_key_set.sv */
// Ordered key set: holds up to CAPACITY keys in insertion order and answers
// insert, remove and query commands, one result per command carrying a status
// and the count after the command. A command is taken only while the block is
// idle. Each command is accepted, then scans the key RAM at one slot per cycle
// through its single read port, stopping at a match or after the held keys. A
// remove then moves each key behind the deleted slot down one slot and closes.
// Every command ends with a commit. A remove's scan and shift together visit the
// held keys once. The result sits in an output register, so the next command is
// taken while the previous result still waits for its transfer. The commit of
// that next command holds until the output register is free.
// The key RAM needs no clearing after reset.
module bounded_ordered_key_set
    import bos_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,  // [31:0] key
    input  logic [1:0]  s_axis_tuser,  // [1:0] cmd
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata,  // [4:0] count, [7:5] zero
    output logic [2:0]  m_axis_tuser   // [2:0] status
);

    dp_cmd_t    dp_cmd;
    dp_stat_t   dp_stat;
    logic [4:0] res_count;

    bos_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .stat     (dp_stat),
        .cmd      (dp_cmd)
    );

    bos_dp u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (dp_cmd),
        .stat       (dp_stat),
        .in_cmd     (s_axis_tuser),
        .in_key     (s_axis_tdata),
        .out_valid  (m_axis_tvalid),
        .out_ready  (m_axis_tready),
        .out_status (m_axis_tuser),
        .out_count  (res_count)
    );

    assign m_axis_tdata = {3'b0, res_count};

    // Issue at most one datapath command per cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({dp_cmd.load, dp_cmd.scan, dp_cmd.shift, dp_cmd.finish}))
        else $error("more than one datapath command at once");

    // Accept input only while no command is in progress
    assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tready |-> !(dp_cmd.scan || dp_cmd.shift || dp_cmd.finish))
        else $error("input ready while a command is in progress");

    // Drop ready after a transfer until the command completes
    assert property (@(posedge clk) disable iff (!rst_n)
        dp_cmd.load |=> !s_axis_tready)
        else $error("input ready right after an accepted command");

    // Commit a result only when the output register can take it
    assert property (@(posedge clk) disable iff (!rst_n)
        dp_cmd.finish |-> (!m_axis_tvalid || m_axis_tready))
        else $error("result committed over an untaken result");

endmodule

/* sim/bounded_ordered_key_set_tb.sv */
module bounded_ordered_key_set_tb;
    import bos_pkg::*;

    localparam logic [1:0]  CMD_SPARE   = 2'd3;
    localparam int          CYCLE_LIMIT = 1_000_000;
    localparam int          RANDOM_CMDS = 1520;
    localparam int          HOLD_CYCLES = 400;
    localparam int          DRAIN_WAIT  = 2 * CAPACITY + 10;
    localparam int          POOL_SIZE   = 24;
    localparam logic [31:0] KEY_MASK    =
        (KEY_BITS >= 32) ? 32'hFFFF_FFFF : ((32'd1 << KEY_BITS) - 32'd1);

    typedef struct packed {
        logic [2:0]       status;
        logic [CNT_W-1:0] count;
    } set_result_t;

    // Tracks the key set contents and the results still owed by the block
    class key_set_tracker;
        logic [31:0] held_keys [CAPACITY];
        int unsigned held;
        set_result_t pending_results [$];
        int unsigned errors;

        function new();
            held   = 0;
            errors = 0;
        endfunction

        // Slot holding the key, or held when absent
        function int unsigned find_key(logic [31:0] k);
            for (int unsigned i = 0; i < held; i++)
                if (held_keys[i] == k)
                    return i;
            return held;
        endfunction

        // Apply an accepted command and queue its result
        function void note_command(logic [1:0] cmd, logic [31:0] key);
            set_result_t res;
            logic [31:0] k;
            int unsigned slot;
            k    = key & KEY_MASK;
            slot = find_key(k);
            case (cmd)
                CMD_INSERT:
                begin
                    if (held >= CAPACITY)
                        res.status = ST_FULL;
                    else if (slot < held)
                        res.status = ST_DUPLICATE;
                    else
                    begin
                        held_keys[held] = k;
                        held++;
                        res.status = ST_INSERTED;
                    end
                end
                CMD_REMOVE:
                begin
                    if (slot < held)
                    begin
                        // Close the gap so later keys keep their order
                        for (int unsigned i = slot; i + 1 < held; i++)
                            held_keys[i] = held_keys[i + 1];
                        held--;
                        res.status = ST_REMOVED;
                    end
                    else
                        res.status = ST_NOTFOUND;
                end
                default:
                    res.status = (slot < held) ? ST_PRESENT : ST_NOTFOUND;
            endcase
            res.count = CNT_W'(held);
            pending_results.push_back(res);
        endfunction

        // Compare one transferred result with the oldest expectation
        function void check_result(logic [2:0] status, logic [7:0] data);
            set_result_t exp_res;
            if (pending_results.size() == 0)
            begin
                $error("unexpected result: status %0d count %0d", status, data[4:0]);
                errors++;
                return;
            end
            exp_res = pending_results.pop_front();
            if (status !== exp_res.status)
            begin
                $error("status: expected %0d, got %0d", exp_res.status, status);
                errors++;
            end
            if (data[4:0] !== exp_res.count)
            begin
                $error("count: expected %0d, got %0d", exp_res.count, data[4:0]);
                errors++;
            end
            if (data[7:5] !== 3'b000)
            begin
                $error("tdata pad: expected 0, got %0d", data[7:5]);
                errors++;
            end
        endfunction

        function int unsigned pending();
            return pending_results.size();
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata;
    logic [1:0]  s_axis_tuser;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [7:0]  m_axis_tdata;
    logic [2:0]  m_axis_tuser;

    key_set_tracker tracker;
    int unsigned    cycles = 0;
    int unsigned    accepted_cmds;
    logic           calm;
    logic [31:0]    key_pool [POOL_SIZE];

    bounded_ordered_key_set uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always
    begin
        clk = 1'b0;
        #10;
        clk = 1'b1;
        #10;
    end

    // Idle length: mostly none or short, now and then long
    function automatic int pick_gap();
        int unsigned r;
        if (calm)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        else if (r < 92)
            return $urandom_range(1, 3);
        else
            return $urandom_range(8, 40);
    endfunction

    // Offer one command and hold it until its transfer
    task automatic send_cmd(input logic [1:0] cmd, input logic [31:0] key);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= key;
        s_axis_tuser  <= cmd;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        tracker.note_command(cmd, key);
        accepted_cmds++;
        @(negedge clk);
    endtask

    // Cycle limit
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    // Check every result transfer
    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
            tracker.check_result(m_axis_tuser, m_axis_tdata);
    end

    // Drive result backpressure, with one long hold-off mid-run
    initial
    begin
        int  stall_left;
        bit  held_off;
        stall_left = 0;
        held_off   = 0;
        m_axis_tready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (!held_off && accepted_cmds > 500)
            begin
                m_axis_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
                held_off = 1;
            end
            else if (stall_left > 0)
            begin
                m_axis_tready <= 1'b0;
                stall_left--;
            end
            else
            begin
                m_axis_tready <= 1'b1;
                if (!calm && $urandom_range(0, 99) < 30)
                    stall_left = pick_gap();
            end
        end
    end

    // Stimulus
    initial
    begin
        int unsigned insert_pct;
        int unsigned r;
        logic [1:0]  cmd;
        logic [31:0] key;
        tracker       = new();
        accepted_cmds = 0;
        calm          = 1'b0;
        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = CMD_INSERT;
        insert_pct    = 50;
        key_pool[0]   = 32'h0000_0000;
        key_pool[1]   = 32'hFFFF_FFFF;
        for (int i = 2; i < POOL_SIZE; i++)
            key_pool[i] = $urandom;

        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Empty set: query, remove and spare selector all miss
        send_cmd(CMD_QUERY,  32'h0000_0000);
        send_cmd(CMD_REMOVE, 32'hFFFF_FFFF);
        send_cmd(CMD_SPARE,  32'h0000_0000);
        // Extreme keys, a duplicate, hits through query and spare selector
        send_cmd(CMD_INSERT, 32'h0000_0000);
        send_cmd(CMD_INSERT, 32'hFFFF_FFFF);
        send_cmd(CMD_INSERT, 32'h0000_0000);
        send_cmd(CMD_QUERY,  32'hFFFF_FFFF);
        send_cmd(CMD_SPARE,  32'h0000_0000);
        send_cmd(CMD_REMOVE, 32'h0000_0000);
        // Fill to capacity
        for (int i = 1; i < CAPACITY; i++)
            send_cmd(CMD_INSERT, 32'h8000_0000 | i);
        // Full wins over duplicate, then a fresh key into a full set
        send_cmd(CMD_INSERT, 32'hFFFF_FFFF);
        send_cmd(CMD_INSERT, 32'h0000_0001);
        // Remove from the middle, the head and the tail, then a miss
        send_cmd(CMD_REMOVE, 32'h8000_0007);
        send_cmd(CMD_REMOVE, 32'hFFFF_FFFF);
        send_cmd(CMD_REMOVE, 32'h8000_0000 | (CAPACITY - 1));
        send_cmd(CMD_REMOVE, 32'h1234_5678);

        // Random commands over a small key pool so hits and a full set are common
        for (int n = 0; n < RANDOM_CMDS; n++)
        begin
            calm = ((n / 120) % 5) == 4;
            if (n % 100 == 0)
                insert_pct = $urandom_range(15, 85);
            r = $urandom_range(0, 99);
            if (r < insert_pct)
                cmd = CMD_INSERT;
            else
            begin
                r = $urandom_range(0, 9);
                cmd = (r < 5) ? CMD_REMOVE : (r < 9) ? CMD_QUERY : CMD_SPARE;
            end
            if ($urandom_range(0, 99) < 85)
                key = key_pool[$urandom_range(0, POOL_SIZE - 1)];
            else
                key = $urandom;
            send_cmd(cmd, key);
        end
        s_axis_tvalid <= 1'b0;
        calm = 1'b0;

        // Drain and let any stray result show up
        while (tracker.pending() != 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);
        if (tracker.errors == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
